@@ rtl/ghost_key_history_fifo_unit_macros.svh @@
// -----------------------------------------------------------------------------
// ghost_key_history_fifo_unit_macros.svh
// Assertion macros for the ghost key history FIFO. Define ASSERT_OFF to drop
// all checks. Macros expect clk and rst_n in scope.
// -----------------------------------------------------------------------------
`ifndef GHOST_KEY_HISTORY_FIFO_UNIT_MACROS_SVH
`define GHOST_KEY_HISTORY_FIFO_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Invariant that holds at every clock edge out of reset.
`define GHKF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define GHKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GHKF_ASSERT_ALWAYS(lbl, expr, msg)
`define GHKF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/ghkf_pkg.sv @@
// -----------------------------------------------------------------------------
// ghkf_pkg
// Types, constants and key helpers shared by the ghost key history FIFO.
// -----------------------------------------------------------------------------
`default_nettype none

package ghkf_pkg;

  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int KEY_IN_W  = 64;
  localparam int LEN_W     = 4;
  localparam int CAP_W     = 5;
  localparam int COUNT_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(KEY_BYTES);

  typedef enum logic [1:0] {
    CMD_ENQ      = 2'd0,
    CMD_DEQ      = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_IN_W-1:0] key_bytes;
    logic [LEN_W-1:0]    key_len;
  } in_t;

  typedef struct packed {
    logic               found;
    logic               evicted;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Broadcast control for the cell row.
  typedef struct packed {
    logic cmp_en;    // latch per-cell match
    logic hit_en;    // matches feed the seen chain
    logic shift_en;  // cells past the seen point take their neighbor
  } cell_ctl_t;

  function automatic logic [LEN_W-1:0] norm_len(input logic [LEN_W-1:0] len);
    norm_len = (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // Clear bytes at and above the length.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_IN_W-1:0] key,
                                                input logic [LEN_W-1:0]    len);
    logic [KEY_W-1:0] res;
    res = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        res[b*8 +: 8] = key[b*8 +: 8];
      end
    end
    norm_key = res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ghkf_cell.sv @@
// -----------------------------------------------------------------------------
// ghkf_cell
// One history slot: holds a key, compares it, shifts toward the old end.
// -----------------------------------------------------------------------------
`default_nettype none

module ghkf_cell
  import ghkf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] key_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic             wr_i,
  input  logic             seen_i,
  output logic             seen_o,
  input  entry_t           nbr_i,
  output entry_t           ent_o
);

  logic             valid_r, valid_nxt;
  logic             hit_r, hit_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             shift;

  assign hit_nxt = ctl.cmp_en ? (valid_r && (len_r == len_i) && (key_r == key_i)) : hit_r;

  // Once an older slot matched (or a drop starts at slot 0), everything younger shifts.
  assign seen_o = seen_i | (ctl.hit_en & hit_r);
  assign shift  = ctl.shift_en & seen_o;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    len_nxt   = len_r;
    if (wr_i) begin
      valid_nxt = 1'b1;
      key_nxt   = key_i;
      len_nxt   = len_i;
    end else if (shift) begin
      valid_nxt = nbr_i.valid;
      key_nxt   = nbr_i.key;
      len_nxt   = nbr_i.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    len_r <= len_nxt;
  end

  assign ent_o = '{valid: valid_r, len: len_r, key: key_r};

endmodule

`default_nettype wire

@@ rtl/ghost_key_history_fifo_unit.sv @@
// -----------------------------------------------------------------------------
// ghost_key_history_fifo_unit
// Bounded FIFO history of evicted keys (2Q ghost list) built as a cell row.
// -----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_data when start is high and busy is low: enqueue,
//   dequeue oldest, remove key, contains query. Keys are compared on length
//   and the bytes below that length.
//   Each transaction yields exactly one result on out_data, shown for one
//   cycle with out_strobe high. The receiver cannot stall; the result is
//   simply presented and taken.
//   Sequence: an accepted command is compared in the cell row, then the cells
//   update, and out_strobe is high in the cycle after the update.
//   A new command is taken only after the previous one has gone through the
//   compare / update sequence of the cell row; busy is high meanwhile. A new
//   command may be accepted in the cycle the previous result is on the strobe.
//   Capacity is written on cfg_data with cfg_valid/cfg_ready; cfg_ready is
//   high whenever the unit is idle.
//   Reset (rst_n low, synchronous) empties the history and sets capacity 16.
//   DEPTH is the number of cells, 1 to 31 (count port is 5 bits).
// -----------------------------------------------------------------------------
`default_nettype none

`include "ghost_key_history_fifo_unit_macros.svh"

module ghost_key_history_fifo_unit
  import ghkf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // command channel
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  // result channel
  output logic             out_strobe,
  output out_t             out_data,
  // capacity register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // ---------------------------------------------------------------------------
  // Sequencer: idle -> compare -> update
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_acc    = start & (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = in_acc ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command held for the whole transaction; key normalized on the way in.
  cmd_t             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  assign cmd_nxt = in_acc ? in_data.cmd : cmd_r;
  assign len_nxt = in_acc ? norm_len(in_data.key_len) : len_r;
  assign key_nxt = in_acc ? norm_key(in_data.key_bytes, norm_len(in_data.key_len)) : key_r;

  // Cell control decode
  cell_ctl_t ctl;
  logic      upd;

  always_comb begin
    ctl = '0;
    upd = 1'b0;
    case (state_r)
      ST_CMP: begin
        ctl.cmp_en = 1'b1;
      end
      ST_UPD: begin
        upd          = 1'b1;
        ctl.hit_en   = (cmd_r == CMD_REMOVE) || (cmd_r == CMD_CONTAINS);
        ctl.shift_en = (cmd_r != CMD_CONTAINS);
      end
      default: begin
        ctl = '0;
        upd = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Occupancy and capacity
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cnt1;
  logic [CW-1:0]    cap_x, eff_cap, cnt_out_x;
  logic             full, evict, wr_en, seen0, found;

  assign cap_nxt = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  // Capacity zero acts as one; above DEPTH acts as DEPTH.
  assign cap_x = CW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_x;
    end
  end

  // A lowered capacity drops only the single oldest key per enqueue.
  assign full  = (CW'(count_r) >= eff_cap) && (count_r != '0);
  assign evict = upd && (cmd_r == CMD_ENQ) && full;
  assign cnt1  = evict ? (count_r - CNT_W'(1)) : count_r;
  assign wr_en = upd && (cmd_r == CMD_ENQ) && (CW'(cnt1) < CW'(DEPTH));

  // Dequeue and eviction start the shift at the oldest slot.
  assign seen0 = upd && (((cmd_r == CMD_DEQ) && (count_r != '0)) || evict);

  // ---------------------------------------------------------------------------
  // Cell row: slot 0 holds the oldest key
  // ---------------------------------------------------------------------------
  logic [DEPTH:0]   seen;
  entry_t           ent_w [DEPTH+1];
  logic [DEPTH-1:0] wr_sel;
  logic [DEPTH-1:0] vld_vec;

  assign seen[0]      = seen0;
  assign ent_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign wr_sel[i]  = wr_en && (cnt1 == CNT_W'(i));
    assign vld_vec[i] = ent_w[i].valid;

    ghkf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .key_i  (key_r),
      .len_i  (len_r),
      .wr_i   (wr_sel[i]),
      .seen_i (seen[i]),
      .seen_o (seen[i+1]),
      .nbr_i  (ent_w[i+1]),
      .ent_o  (ent_w[i])
    );
  end

  // Remove and contains start the chain clear, so its end is the match flag.
  assign found = upd && ctl.hit_en && seen[DEPTH];

  always_comb begin
    count_nxt = count_r;
    if (upd) begin
      case (cmd_r)
        CMD_ENQ:      count_nxt = cnt1 + CNT_W'(wr_en);
        CMD_DEQ:      count_nxt = (count_r != '0) ? (count_r - CNT_W'(1)) : count_r;
        CMD_REMOVE:   count_nxt = found ? (count_r - CNT_W'(1)) : count_r;
        CMD_CONTAINS: count_nxt = count_r;
        default:      count_nxt = count_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  assign cnt_out_x = CW'(count_nxt);

  always_comb begin
    out_nxt.found     = found;
    out_nxt.evicted   = evict;
    out_nxt.count     = cnt_out_x[COUNT_W-1:0];
    out_nxt.empty_res = (count_nxt == '0);
  end

  assign out_valid_nxt = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    len_r <= len_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `GHKF_ASSERT_ALWAYS(a_count_max, CW'(count_r) <= CW'(DEPTH), "count above depth")
  `GHKF_ASSERT_ALWAYS(a_valid_count, $countones(vld_vec) == int'(count_r), "valid slots disagree with count")
  `GHKF_ASSERT_ALWAYS(a_found_evict, !out_valid_r || !(out_r.found && out_r.evicted), "found and evicted together")
  `GHKF_ASSERT_NEXT(a_no_early_result, in_acc, !out_valid_r, "result strobe right after accept")

endmodule

`default_nettype wire

@@ tb/ghkf_history_checker.sv @@
// ----------------------------------------------------------------------------
// ghkf_history_checker
// Watches the command, result and capacity channels of the ghost key history
// FIFO, keeps its own copy of the history and compares every result.
// ----------------------------------------------------------------------------
module ghkf_history_checker
  import ghkf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_t              in_data,
  input  logic             out_strobe,
  input  out_t             out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               results,
  output int               hits,
  output int               evictions
);

  // shadow history, oldest in slot 0
  logic [KEY_W-1:0] hist_key [DEPTH];
  logic [LEN_W-1:0] hist_len [DEPTH];
  int               hist_count;
  logic [CAP_W-1:0] cap_reg;

  out_t outcome_q[$];
  int   n_bad     = 0;
  int   n_results = 0;
  int   n_hits    = 0;
  int   n_evict   = 0;

  function automatic void drop_slot(int idx);
    for (int i = idx; i + 1 < hist_count; i++) begin
      hist_key[i] = hist_key[i+1];
      hist_len[i] = hist_len[i+1];
    end
    hist_count--;
  endfunction

  // oldest matching slot, -1 if none
  function automatic int find_slot(logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
    for (int i = 0; i < hist_count; i++) begin
      if (hist_len[i] == len && hist_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic out_t apply_op(in_t c);
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    int               limit;
    int               idx;
    out_t             r;
    len   = (c.key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : c.key_len;
    key   = c.key_bytes & ((len >= LEN_W'(KEY_BYTES)) ? {KEY_W{1'b1}} :
                           ((64'd1 << (8 * len)) - 64'd1));
    limit = (cap_reg == '0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
    r     = '0;
    case (c.cmd)
      CMD_ENQ: begin
        // at or over capacity: only the single oldest goes
        if (hist_count >= limit && hist_count > 0) begin
          drop_slot(0);
          r.evicted = 1'b1;
        end
        if (hist_count < DEPTH) begin
          hist_key[hist_count] = key;
          hist_len[hist_count] = len;
          hist_count++;
        end
      end
      CMD_DEQ: begin
        if (hist_count > 0) drop_slot(0);
      end
      CMD_REMOVE: begin
        idx = find_slot(key, len);
        if (idx >= 0) begin
          drop_slot(idx);
          r.found = 1'b1;
        end
      end
      default: r.found = (find_slot(key, len) >= 0);
    endcase
    r.count     = COUNT_W'(hist_count);
    r.empty_res = (hist_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    logic bad;
    if (!rst_n) begin
      hist_count = 0;
      cap_reg    = CAP_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        hist_key[i] = '0;
        hist_len[i] = '0;
      end
      outcome_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (out_strobe) begin
        if (outcome_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"ERROR: result with no transaction outstanding: ",
                      "found=%0b evicted=%0b count=%0d empty=%0b"},
                     out_data.found, out_data.evicted, out_data.count,
                     out_data.empty_res);
        end else begin
          want = outcome_q.pop_front();
          n_results++;
          if (want.found)   n_hits++;
          if (want.evicted) n_evict++;
          bad = (out_data.found !== want.found) || (out_data.evicted !== want.evicted) ||
                (out_data.count !== want.count) || (out_data.empty_res !== want.empty_res);
          if (bad) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"ERROR: result %0d exp found=%0b evicted=%0b count=%0d empty=%0b, ",
                        "got found=%0b evicted=%0b count=%0d empty=%0b"},
                       n_results, want.found, want.evicted, want.count, want.empty_res,
                       out_data.found, out_data.evicted, out_data.count,
                       out_data.empty_res);
          end
        end
      end
      // a result shows up only after its command's compare and update states, so
      // pushing after the compare cannot mix the two
      if (start && !busy) outcome_q.push_back(apply_op(in_data));
    end
    errors    <= n_bad;
    pending   <= outcome_q.size();
    results   <= n_results;
    hits      <= n_hits;
    evictions <= n_evict;
  end

endmodule

@@ tb/ghost_key_history_fifo_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ghost_key_history_fifo_unit_tb
// Drives commands and capacity writes into the ghost key history FIFO; a
// checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module ghost_key_history_fifo_unit_tb;
  import ghkf_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 73;
  localparam int POOL_SIZE   = 8;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  in_t              in_data   = '0;
  logic             cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             out_strobe;
  out_t             out_data;
  logic             cfg_ready;

  int errors, pending, results, hits, evictions;
  int cycles   = 0;
  int settings = 0;
  bit no_idle  = 1'b0;

  // Keys are drawn mostly from a small pool so that remove and contains
  // actually hit and duplicates pile up. Pool keys are stored with unused
  // bytes cleared; garbage goes back into those bytes on each use.
  logic [KEY_W-1:0] pool_key [POOL_SIZE];
  logic [LEN_W-1:0] pool_len [POOL_SIZE];

  // Per phase: capacity written and the command mix (percent enqueue,
  // dequeue, remove; the rest is contains). Phase 1 shrinks capacity under
  // a full history, phases 3 and 4 hit the zero and over-range settings.
  int phase_cap [N_PHASES] = '{16, 4, 1, 0, 31, 2, 17, 8, -1, 16};
  int phase_enq [N_PHASES] = '{70, 40, 45, 45, 70, 40, 50, 20, 45, 35};
  int phase_deq [N_PHASES] = '{ 5, 15, 15, 15,  5, 20, 15, 45, 15, 20};
  int phase_rem [N_PHASES] = '{15, 25, 20, 20, 15, 20, 20, 20, 20, 25};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ghost_key_history_fifo_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ghkf_history_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .results   (results),
    .hits      (hits),
    .evictions (evictions)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL ghost_key_history_fifo_unit");
      $finish;
    end
  end

  function automatic in_t mk_cmd(cmd_t c, logic [KEY_IN_W-1:0] k, logic [LEN_W-1:0] l);
    in_t r;
    r.cmd       = c;
    r.key_bytes = k;
    r.key_len   = l;
    return r;
  endfunction

  // Random command with the given mix. One in five keys is fully random,
  // the rest come from the pool with random junk in the unused bytes; pool
  // keys of full length sometimes carry an over-range length instead.
  function automatic in_t rand_cmd(int enq, int deq, int rem);
    int               r;
    int               idx;
    cmd_t             c;
    logic [KEY_W-1:0] mask;
    logic [LEN_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < enq)                  c = CMD_ENQ;
    else if (r < enq + deq)       c = CMD_DEQ;
    else if (r < enq + deq + rem) c = CMD_REMOVE;
    else                          c = CMD_CONTAINS;
    if ($urandom_range(0, 4) == 0)
      return mk_cmd(c, {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)));
    idx = $urandom_range(0, POOL_SIZE - 1);
    len = pool_len[idx];
    if (len == LEN_MAX && $urandom_range(0, 2) == 0) len = LEN_W'($urandom_range(8, 15));
    mask = (len >= LEN_MAX) ? {KEY_W{1'b1}} : ((64'd1 << (8 * len)) - 64'd1);
    return mk_cmd(c, pool_key[idx] | ({$urandom, $urandom} & ~mask), len);
  endfunction

  // One command transaction. start stays high from one command to the next
  // unless an idle gap is inserted; busy is read at the edge, i.e. the value
  // the block itself sampled.
  task automatic send_cmd(input in_t item);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = no_idle ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every predicted result has been checked.
  // The first edge lets the checker count the last accepted command.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Capacity writes happen only with the history idle.
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_idle();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    int cap;
    int l;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset capacity (16) ----
    // empty history: nothing to find, dequeue is a no-op
    send_cmd(mk_cmd(CMD_CONTAINS, '1, 4'd8));
    send_cmd(mk_cmd(CMD_DEQ, '0, 4'd0));
    send_cmd(mk_cmd(CMD_REMOVE, '1, 4'd8));
    // full-length key, then the same key with a saturated length
    send_cmd(mk_cmd(CMD_ENQ, '1, 4'd8));
    send_cmd(mk_cmd(CMD_ENQ, '1, 4'd15));
    send_cmd(mk_cmd(CMD_CONTAINS, '1, 4'd12));
    // short key: junk above the length is ignored, length must match
    send_cmd(mk_cmd(CMD_ENQ, 64'hDEAD_BEEF_0000_00A5, 4'd1));
    send_cmd(mk_cmd(CMD_CONTAINS, 64'h0000_0000_0000_00A5, 4'd1));
    send_cmd(mk_cmd(CMD_CONTAINS, 64'h0000_0000_0000_00A5, 4'd2));
    // zero-length key matches any bytes
    send_cmd(mk_cmd(CMD_ENQ, '0, 4'd0));
    send_cmd(mk_cmd(CMD_CONTAINS, 64'h1234, 4'd0));
    // duplicates: remove takes the oldest one only
    send_cmd(mk_cmd(CMD_REMOVE, '1, 4'd8));
    send_cmd(mk_cmd(CMD_CONTAINS, '1, 4'd8));
    send_cmd(mk_cmd(CMD_REMOVE, '1, 4'd9));
    send_cmd(mk_cmd(CMD_REMOVE, '1, 4'd8));
    send_cmd(mk_cmd(CMD_DEQ, '1, 4'd3));
    send_cmd(mk_cmd(CMD_ENQ, 64'h0123_4567_89AB_CDEF, 4'd8));
    send_cmd(mk_cmd(CMD_ENQ, '0, 4'd0));
    send_cmd(mk_cmd(CMD_REMOVE, 64'hFF, 4'd0));
    send_cmd(mk_cmd(CMD_CONTAINS, 64'h0123_4567_89AB_CDEF, 4'd7));
    // drain and dequeue past empty
    repeat (4) send_cmd(mk_cmd(CMD_DEQ, '0, 4'd0));

    // ---- random phases, one capacity setting each ----
    for (int p = 0; p < N_PHASES; p++) begin
      cap = (phase_cap[p] < 0) ? $urandom_range(1, 16) : phase_cap[p];
      write_capacity(CAP_W'(cap));
      for (int i = 0; i < POOL_SIZE; i++) begin
        l           = $urandom_range(0, 10);
        pool_len[i] = (l > 8) ? LEN_MAX : LEN_W'(l);
        pool_key[i] = {$urandom, $urandom} &
                      ((pool_len[i] >= LEN_MAX) ? {KEY_W{1'b1}} :
                       ((64'd1 << (8 * pool_len[i])) - 64'd1));
      end
      // phase 2 runs back to back with no idle cycles at all
      no_idle = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mid-phase drain with the history still populated
        if (p == 5 && i == PHASE_ITEMS / 2) wait_idle();
        send_cmd(rand_cmd(phase_enq[p], phase_deq[p], phase_rem[p]));
      end
    end

    wait_idle();
    repeat (12) @(posedge clk);

    $display("Checked %0d results (%0d key matches, %0d evictions) across %0d capacity writes,",
             results, hits, evictions, settings);
    $display("covering empty and full histories, shrunk capacity and out-of-range settings.");
    if (errors == 0 && pending == 0) begin
      $display("PASS ghost_key_history_fifo_unit");
    end else begin
      $display("FAIL ghost_key_history_fifo_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ghkf_pkg.sv
rtl/ghkf_cell.sv
rtl/ghost_key_history_fifo_unit.sv
tb/ghkf_history_checker.sv
tb/ghost_key_history_fifo_unit_tb.sv
